/* design/abg_pkg.sv */
// shared types and constants for the alpha-beta-gamma tracker
`timescale 1ns / 1ps
package abg_pkg;

	// width of the second operand of the shared multiply/divide unit (holds dt squared)
	localparam int OPB_BITS = 32;

	// width of the step time field
	localparam int STEP_BITS = 16;

	// width of the measured and estimated position fields
	localparam int POS_BITS = 32;

	// configuration register indexes
	localparam logic [1:0] REG_ALPHA = 2'd0;
	localparam logic [1:0] REG_BETA  = 2'd1;
	localparam logic [1:0] REG_GAMMA = 2'd2;

	// operation codes of the shared unit
	localparam logic OP_MUL = 1'b0;
	localparam logic OP_DIV = 1'b1;

	// command from the sequencer to the shared unit
	typedef struct packed {
		logic start;
		logic op;
	} abg_cmd_t;

endpackage

/* design/alpha_beta_gamma_tracker_unit.sv */
// alpha-beta-gamma tracking filter top level with sequencer and state
`timescale 1ns / 1ps
// One-axis alpha-beta-gamma tracker. Position, velocity and acceleration are
// signed fixed point with FRACTION_BITS fraction bits, cleared at reset; gains
// are unsigned Q0.GAIN_BITS registers written through the cfg port (index 0
// alpha, 1 beta, 2 gamma). Each transfer on the input channel yields exactly one
// result. For a nonzero step, six multiplies and two divides run one after
// another on a single bit-serial multiply/divide unit, one bit per cycle. A zero
// step holds the state and sets step_error. in_ready is high only while the
// sequencer is idle; a finished result waits in the output register.
module alpha_beta_gamma_tracker_unit #(
	parameter int FRACTION_BITS = 16,
	parameter int GAIN_BITS     = 16
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [1:0]                          cfg_index,
	input  logic [GAIN_BITS-1:0]                cfg_data,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic [abg_pkg::STEP_BITS-1:0]       step_time,
	input  logic signed [abg_pkg::POS_BITS-1:0] measured_position,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic signed [abg_pkg::POS_BITS-1:0] estimated_position,
	output logic                                step_error
);
	import abg_pkg::*;

	localparam int SW = POS_BITS + FRACTION_BITS;
	localparam int MW = SW + 1;
	localparam int PW = MW + OPB_BITS;
	localparam logic [SW-1:0] SMAX = {1'b0, {(SW-1){1'b1}}};
	localparam logic [PW-1:0] SMAX_W = {{(PW-SW){1'b0}}, SMAX};
	localparam logic [PW-1:0] TWO_SMAX = (PW'(1) << SW) - PW'(2);
	localparam logic [GAIN_BITS-1:0] ALPHA_RST = GAIN_BITS'((64'd1 << GAIN_BITS) / 2);
	localparam logic [GAIN_BITS-1:0] BETA_RST  = GAIN_BITS'(((64'd4 << GAIN_BITS) + 5) / 10);
	localparam logic [GAIN_BITS-1:0] GAMMA_RST = GAIN_BITS'(((64'd1 << GAIN_BITS) + 5) / 10);

	// sequencer states
	localparam logic [3:0] ST_IDLE = 4'd0;
	localparam logic [3:0] ST_HALF = 4'd1;
	localparam logic [3:0] ST_VT   = 4'd2;
	localparam logic [3:0] ST_AT   = 4'd3;
	localparam logic [3:0] ST_RES  = 4'd4;
	localparam logic [3:0] ST_GA   = 4'd5;
	localparam logic [3:0] ST_GB   = 4'd6;
	localparam logic [3:0] ST_DB   = 4'd7;
	localparam logic [3:0] ST_GG   = 4'd8;
	localparam logic [3:0] ST_DG   = 4'd9;
	localparam logic [3:0] ST_FIN  = 4'd10;

	logic [3:0] state_q;
	logic       wait_q;
	logic       err_q;

	logic [GAIN_BITS-1:0] alpha_q, beta_q, gamma_q;
	logic signed [SW-1:0] p_q, v_q, a_q;
	logic [STEP_BITS-1:0]  dt_q;
	logic [OPB_BITS-1:0]   dt2_q;
	logic signed [POS_BITS-1:0] meas_q;
	logic signed [SW-1:0] half_q, vt_q, pp_q, pv_q;
	logic [SW-1:0]        rm_q, gpb_q, gpg_q;
	logic                 rn_q;

	logic                 out_valid_q;
	logic [POS_BITS-1:0]  est_q;
	logic                 serr_q;

	abg_cmd_t            cmd;
	logic [MW-1:0]       opa;
	logic [OPB_BITS-1:0] opb;
	logic                done;
	logic [PW-1:0]       prod;

	logic                    op_state;
	logic                    step_done;
	logic [PW-1:0]           hm;
	logic [SW-1:0]           gp;
	logic [PW-1:0]           quo;
	logic signed [SW+1:0]    r_full;
	logic [SW+1:0]           r_mag;
	logic [SW-1:0]           p_mag;
	logic [POS_BITS-1:0]     p_int;
	logic                    out_free;

	// magnitude of a state value
	function automatic logic [SW-1:0] mag(input logic signed [SW-1:0] x);
		return x[SW-1] ? SW'(-x) : SW'(x);
	endfunction

	// clamp a magnitude to the state range and restore its sign
	function automatic logic signed [SW-1:0] capped(input logic [PW-1:0] m, input logic neg);
		logic [SW-1:0] mc;
		mc = (m > SMAX_W) ? SMAX : m[SW-1:0];
		return neg ? $signed(-mc) : $signed(mc);
	endfunction

	// sign extend a state value by two bits
	function automatic logic signed [SW+1:0] ext(input logic signed [SW-1:0] x);
		return {{2{x[SW-1]}}, x};
	endfunction

	// saturate a widened sum to the state range
	function automatic logic signed [SW-1:0] sat(input logic signed [SW+1:0] x);
		logic signed [SW-1:0] r;
		if (x > ext($signed(SMAX))) begin
			r = $signed(SMAX);
		end else if (x < ext($signed(~SMAX))) begin
			r = $signed(~SMAX);
		end else begin
			r = x[SW-1:0];
		end
		return r;
	endfunction

	// shared multiply/divide unit
	abg_muldiv #(
		.MW(MW)
	) u_muldiv (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.opa    (opa),
		.opb    (opb),
		.done   (done),
		.result (prod)
	);

	// operand selection per sequencer state
	always_comb begin
		op_state = 1'b0;
		cmd.op   = OP_MUL;
		opa      = '0;
		opb      = '0;
		case (state_q)
			ST_HALF: begin
				op_state = 1'b1;
				opa = {1'b0, mag(a_q)};
				opb = dt2_q;
			end
			ST_VT: begin
				op_state = 1'b1;
				opa = {1'b0, mag(v_q)};
				opb = {{(OPB_BITS-STEP_BITS){1'b0}}, dt_q};
			end
			ST_AT: begin
				op_state = 1'b1;
				opa = {1'b0, mag(a_q)};
				opb = {{(OPB_BITS-STEP_BITS){1'b0}}, dt_q};
			end
			ST_GA: begin
				op_state = 1'b1;
				opa = {1'b0, rm_q};
				opb = {{(OPB_BITS-GAIN_BITS){1'b0}}, alpha_q};
			end
			ST_GB: begin
				op_state = 1'b1;
				opa = {1'b0, rm_q};
				opb = {{(OPB_BITS-GAIN_BITS){1'b0}}, beta_q};
			end
			ST_DB: begin
				op_state = 1'b1;
				cmd.op = OP_DIV;
				opa = {1'b0, gpb_q};
				opb = {{(OPB_BITS-STEP_BITS){1'b0}}, dt_q};
			end
			ST_GG: begin
				op_state = 1'b1;
				opa = {1'b0, rm_q};
				opb = {{(OPB_BITS-GAIN_BITS){1'b0}}, gamma_q};
			end
			ST_DG: begin
				op_state = 1'b1;
				cmd.op = OP_DIV;
				opa = {gpg_q, 1'b0};
				opb = dt2_q;
			end
			default: begin
				op_state = 1'b0;
			end
		endcase
		cmd.start = op_state && !wait_q;
		step_done = op_state && done;
	end

	// result shaping
	always_comb begin
		hm     = (prod > TWO_SMAX) ? SMAX_W : (prod >> 1);
		gp     = prod[GAIN_BITS +: SW];
		quo    = {{OPB_BITS{1'b0}}, prod[MW-1:0]};
		r_full = ext($signed({meas_q, {FRACTION_BITS{1'b0}}})) - ext(pp_q);
		r_mag  = r_full[SW+1] ? SW'(0) + (-r_full) : r_full;
		p_mag  = mag(p_q);
		p_int  = p_q[SW-1] ? -p_mag[SW-1:FRACTION_BITS] : p_mag[SW-1:FRACTION_BITS];
		out_free = !out_valid_q || out_ready;
	end

	// gain registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			alpha_q <= ALPHA_RST;
			beta_q  <= BETA_RST;
			gamma_q <= GAMMA_RST;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_ALPHA: alpha_q <= cfg_data;
				REG_BETA:  beta_q  <= cfg_data;
				REG_GAMMA: gamma_q <= cfg_data;
				default:   alpha_q <= alpha_q;
			endcase
		end
	end

	// sequencer and filter state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			wait_q      <= 1'b0;
			err_q       <= 1'b0;
			p_q         <= '0;
			v_q         <= '0;
			a_q         <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.start) begin
				wait_q <= 1'b1;
			end else if (step_done) begin
				wait_q <= 1'b0;
			end
			// output register: load a finished result or drop a taken one
			if (state_q == ST_FIN && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						err_q   <= (step_time == '0);
						state_q <= (step_time == '0) ? ST_FIN : ST_HALF;
					end
				end
				ST_HALF: if (step_done) state_q <= ST_VT;
				ST_VT:   if (step_done) state_q <= ST_AT;
				ST_AT:   if (step_done) state_q <= ST_RES;
				ST_RES:  state_q <= ST_GA;
				ST_GA: begin
					if (step_done) begin
						p_q     <= sat(ext(pp_q) + ext(capped({{(PW-SW){1'b0}}, gp}, rn_q)));
						state_q <= ST_GB;
					end
				end
				ST_GB:   if (step_done) state_q <= ST_DB;
				ST_DB: begin
					if (step_done) begin
						v_q     <= sat(ext(pv_q) + ext(capped(quo, rn_q)));
						state_q <= ST_GG;
					end
				end
				ST_GG:   if (step_done) state_q <= ST_DG;
				ST_DG: begin
					if (step_done) begin
						a_q     <= sat(ext(a_q) + ext(capped(quo, rn_q)));
						state_q <= ST_FIN;
					end
				end
				ST_FIN: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && in_valid) begin
			dt_q   <= step_time;
			dt2_q  <= OPB_BITS'(step_time) * OPB_BITS'(step_time);
			meas_q <= measured_position;
		end
		if (state_q == ST_HALF && step_done) begin
			half_q <= capped(hm, a_q[SW-1]);
		end
		if (state_q == ST_VT && step_done) begin
			vt_q <= capped(prod, v_q[SW-1]);
		end
		if (state_q == ST_AT && step_done) begin
			pp_q <= sat(ext(p_q) + ext(vt_q) + ext(half_q));
			pv_q <= sat(ext(v_q) + ext(capped(prod, a_q[SW-1])));
		end
		if (state_q == ST_RES) begin
			rm_q <= r_mag[SW-1:0];
			rn_q <= r_full[SW+1];
		end
		if (state_q == ST_GB && step_done) begin
			gpb_q <= gp;
		end
		if (state_q == ST_GG && step_done) begin
			gpg_q <= gp;
		end
		if (state_q == ST_FIN && out_free) begin
			est_q  <= p_int;
			serr_q <= err_q;
		end
	end

	assign cfg_ready          = 1'b1;
	assign in_ready           = (state_q == ST_IDLE);
	assign out_valid          = out_valid_q;
	assign estimated_position = $signed(est_q);
	assign step_error         = serr_q;

endmodule

/* design/abg_muldiv.sv */
// shared bit-serial unsigned multiplier and restoring divider
`timescale 1ns / 1ps
module abg_muldiv #(
	parameter int MW = 49
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  abg_pkg::abg_cmd_t            cmd,
	input  logic [MW-1:0]                opa,
	input  logic [abg_pkg::OPB_BITS-1:0] opb,
	output logic                         done,
	output logic [MW+abg_pkg::OPB_BITS-1:0] result
);
	import abg_pkg::*;

	localparam int PW = MW + OPB_BITS;
	localparam int CW = $clog2(MW);

	logic          busy_q;
	logic          op_q;
	logic          done_q;
	logic [CW-1:0] cnt_q;
	logic [MW-1:0] a_q;
	logic [OPB_BITS-1:0] b_q;
	logic [PW-1:0] p_q;

	logic [MW:0]         mul_sum;
	logic [OPB_BITS:0]   rem_sh;
	logic                rem_ge;
	logic [OPB_BITS:0]   rem_diff;
	logic [OPB_BITS-1:0] rem_new;
	logic [PW-1:0]       p_next;

	// one multiplier bit or one quotient bit per cycle
	always_comb begin
		mul_sum  = {1'b0, p_q[PW-1:OPB_BITS]} + (p_q[0] ? {1'b0, a_q} : '0);
		rem_sh   = {p_q[PW-1:MW], p_q[MW-1]};
		rem_ge   = rem_sh >= {1'b0, b_q};
		rem_diff = rem_sh - {1'b0, b_q};
		rem_new  = rem_ge ? rem_diff[OPB_BITS-1:0] : rem_sh[OPB_BITS-1:0];
		if (op_q == OP_DIV) begin
			p_next = {rem_new, p_q[MW-2:0], rem_ge};
		end else begin
			p_next = {mul_sum, p_q[OPB_BITS-1:1]};
		end
	end

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
			op_q   <= OP_MUL;
		end else begin
			done_q <= 1'b0;
			if (cmd.start) begin
				busy_q <= 1'b1;
				op_q   <= cmd.op;
				cnt_q  <= (cmd.op == OP_DIV) ? CW'(MW - 1) : CW'(OPB_BITS - 1);
			end else if (busy_q) begin
				cnt_q <= cnt_q - CW'(1);
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		if (cmd.start) begin
			a_q <= opa;
			b_q <= opb;
			if (cmd.op == OP_DIV) begin
				p_q <= {{OPB_BITS{1'b0}}, opa};
			end else begin
				p_q <= {{MW{1'b0}}, opb};
			end
		end else if (busy_q) begin
			p_q <= p_next;
		end
	end

	assign done   = done_q;
	assign result = p_q;

endmodule
